// File: sv/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// shared types and constants of the rolling compounded return unit
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int          MAX_WINDOW_DEF    = 64;
    localparam int          FRACTION_BITS_DEF = 24;
    localparam int          DATA_W            = 32;
    localparam int          WLEN_W            = 7;
    localparam logic [6:0]  WLEN_RESET        = 7'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_DONE
    } t_state;

    // controls of the shared multiply-accumulate unit
    typedef struct packed {
        logic init;   // running value to 1.0, flag cleared
        logic mul;    // product of running value and sample
        logic acc;    // add shifted product, clamp
        logic fin;    // subtract 1.0, clamp
    } t_mac_ctrl;

endpackage

// File: sv/rcr_hist.sv
// ----------------------------------------------------------------------------
// rcr_hist
// sample history memory, one write and one registered read port
// ----------------------------------------------------------------------------
module rcr_hist
    import rcr_pkg::*;
#(
    parameter int DEPTH = MAX_WINDOW_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rcr_mac.sv
// ----------------------------------------------------------------------------
// rcr_mac
// shared multiply and saturating accumulate unit for the running value
// ----------------------------------------------------------------------------
module rcr_mac
    import rcr_pkg::*;
#(
    parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [DATA_W-1:0] i_sample,
    output logic signed [DATA_W-1:0] o_ret,
    output logic                     o_sat
);

    localparam int PW = 2 * DATA_W;
    localparam logic signed [DATA_W-1:0] ONE_W = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] MAX_P = PW'(2147483647);
    localparam logic signed [PW-1:0] MIN_P = ~MAX_P;
    localparam logic signed [DATA_W:0] MAX_D = (DATA_W + 1)'(2147483647);
    localparam logic signed [DATA_W:0] MIN_D = ~MAX_D;

    logic signed [DATA_W-1:0] r_ret, n_ret;
    logic signed [PW-1:0]     r_prod;
    logic                     r_sat, n_sat;
    logic signed [PW-1:0]     shifted;
    logic signed [PW-1:0]     sum;
    logic signed [DATA_W:0]   diff;

    always_comb begin
        shifted = r_prod >>> FRAC_BITS;   // floor division
        sum     = PW'(r_ret) + shifted;
        diff    = (DATA_W + 1)'(r_ret) - (DATA_W + 1)'(ONE_W);
        n_ret   = r_ret;
        n_sat   = r_sat;
        if (i_ctrl.init) begin
            n_ret = ONE_W;
            n_sat = 1'b0;
        end else if (i_ctrl.acc) begin
            if (sum > MAX_P) begin
                n_ret = DATA_W'(MAX_P);
                n_sat = 1'b1;
            end else if (sum < MIN_P) begin
                n_ret = DATA_W'(MIN_P);
                n_sat = 1'b1;
            end else begin
                n_ret = sum[DATA_W-1:0];
            end
        end else if (i_ctrl.fin) begin
            if (diff > MAX_D) begin
                n_ret = DATA_W'(MAX_D);
                n_sat = 1'b1;
            end else if (diff < MIN_D) begin
                n_ret = DATA_W'(MIN_D);
                n_sat = 1'b1;
            end else begin
                n_ret = diff[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_sat <= n_sat;
        if (i_ctrl.mul) begin
            r_prod <= r_ret * i_sample;
        end
    end

    assign o_ret = r_ret;
    assign o_sat = r_sat;

endmodule

// File: sv/rolling_compounded_return_unit.sv
// ----------------------------------------------------------------------------
// rolling_compounded_return_unit
// compounded return over a sliding window of signed fixed-point returns
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready carry one sample and a series_start flag
// per transaction; series_start empties the window before the sample is kept
// output channel: o_valid / i_ready carry the window return and saturation flag
// config: apb-style port, window_length at byte address 0 (7 bits, reset 1)
// a sample that leaves the window short of window_length gives no result and
// the block is ready again in the next cycle
// otherwise, with L the effective window length, the result shows on o_valid
// after these states, and o_ready is low meanwhile: ST_LOAD, then L pairs of
// ST_MUL and ST_ACC on the single shared multiplier and adder (each step
// needs the previous running value), ST_FIN for the final subtraction and
// ST_DONE to move the result to the output register
// so the next sample is taken only once the block is back in ST_IDLE
// a stalled receiver holds the result in the output register; the next sample
// is still taken and the block waits before its own result until the slot frees
// reset (synchronous, active low) clears write slot, fill count, window length
// and handshake state; the history memory is not cleared, it is only ever
// read at entries written in the current series
// ----------------------------------------------------------------------------
module rolling_compounded_return_unit
    import rcr_pkg::*;
#(
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_series_start,
    // output channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_window_return,
    output logic                     o_saturated,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;
    localparam int XW = LW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
    localparam logic [LW-1:0] MAX_FILL  = LW'(MAX_WINDOW);

    t_state r_state, n_state;

    logic [WLEN_W-1:0] r_window_length;
    logic [AW-1:0]     r_write_slot, n_write_slot;
    logic [LW-1:0]     r_fill, n_fill;
    logic [LW-1:0]     r_left, n_left;
    logic [AW-1:0]     r_rd_slot, n_rd_slot;
    logic              r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_ret;
    logic              r_out_sat;

    logic              in_txn;
    logic              cfg_wr;
    logic [CW-1:0]     len_c;
    logic [LW-1:0]     eff_len;
    logic [AW-1:0]     waddr;
    logic [LW-1:0]     fill_base;
    logic [XW-1:0]     start_x;
    logic [AW-1:0]     start_slot;
    logic              has_result;
    logic              rd_en;
    logic              out_load;
    logic [AW-1:0]     rd_next;
    t_mac_ctrl         mac_ctrl;
    logic [DATA_W-1:0] hist_rdata;
    logic signed [DATA_W-1:0] mac_ret;
    logic              mac_sat;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - WLEN_W){1'b0}}, r_window_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WLEN_RESET;
        end else if (cfg_wr && !paddr[2]) begin
            r_window_length <= pwdata[WLEN_W-1:0];
        end
    end

    // effective window length: zero acts as one, clamp to the history depth
    always_comb begin
        if (r_window_length == '0) begin
            len_c = CW'(1);
        end else if (CW'(r_window_length) > CW'(MAX_WINDOW)) begin
            len_c = CW'(MAX_WINDOW);
        end else begin
            len_c = CW'(r_window_length);
        end
        eff_len = len_c[LW-1:0];
    end

    // ------------------------------------------------------------------
    // history bookkeeping at the input transaction
    // ------------------------------------------------------------------
    assign in_txn = i_valid && o_ready;

    always_comb begin
        waddr        = i_series_start ? '0 : r_write_slot;
        n_write_slot = (waddr == LAST_SLOT) ? '0 : waddr + AW'(1);
        fill_base    = i_series_start ? '0 : r_fill;
        n_fill       = (fill_base < MAX_FILL) ? fill_base + LW'(1) : fill_base;
        has_result   = (n_fill >= eff_len);
        // oldest sample of the window, counted back from the next write slot
        if (XW'(n_write_slot) >= XW'(eff_len)) begin
            start_x = XW'(n_write_slot) - XW'(eff_len);
        end else begin
            start_x = XW'(n_write_slot) + XW'(MAX_WINDOW) - XW'(eff_len);
        end
        start_slot = start_x[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_fill       <= '0;
        end else if (in_txn) begin
            r_write_slot <= n_write_slot;
            r_fill       <= n_fill;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_txn && has_result) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                n_state = (r_left == LW'(1)) ? ST_FIN : ST_MUL;
            end
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    assign rd_next = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + AW'(1);

    always_comb begin
        o_ready  = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        mac_ctrl = '0;
        n_left   = r_left;
        n_rd_slot = r_rd_slot;
        case (r_state)
            ST_IDLE: begin
                o_ready   = 1'b1;
                n_left    = eff_len;
                n_rd_slot = start_slot;
            end
            ST_LOAD: begin
                rd_en         = 1'b1;
                n_rd_slot     = rd_next;
                mac_ctrl.init = 1'b1;
            end
            ST_MUL: begin
                // prefetch the next sample while the product settles
                rd_en        = (r_left != LW'(1));
                n_rd_slot    = rd_en ? rd_next : r_rd_slot;
                mac_ctrl.mul = 1'b1;
            end
            ST_ACC: begin
                mac_ctrl.acc = 1'b1;
                n_left       = r_left - LW'(1);
            end
            ST_FIN: begin
                mac_ctrl.fin = 1'b1;
            end
            ST_DONE: begin
                out_load = !r_out_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_rd_slot <= n_rd_slot;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ret <= mac_ret;
            r_out_sat <= mac_sat;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_window_return = r_out_ret;
    assign o_saturated     = r_out_sat;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    rcr_hist #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_txn),
        .i_waddr (waddr),
        .i_wdata (i_sample),
        .i_re    (rd_en),
        .i_raddr (r_rd_slot),
        .o_rdata (hist_rdata)
    );

    rcr_mac #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_sample (hist_rdata),
        .o_ret    (mac_ret),
        .o_sat    (mac_sat)
    );

endmodule

// File: sv/rcr_checker.sv
// ----------------------------------------------------------------------------
// rcr_checker
// port-level checks of the rolling compounded return unit
// ----------------------------------------------------------------------------
module rcr_checker
    import rcr_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [DATA_W-1:0] o_window_return,
    input logic                     o_saturated,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [2:0]               paddr,
    input logic [31:0]              pwdata,
    input logic [31:0]              prdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_window_return)
                                && $stable(o_saturated))
        else $error("result changed while stalled");

    // a result appears only after the block has been busy computing
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result without computation");

    // the window length reads back as written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> paddr[2] || (prdata == {25'd0, $past(pwdata[6:0])}))
        else $error("window length readback mismatch");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind rolling_compounded_return_unit rcr_checker u_rcr_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression bench for the rolling compounded return unit
// ----------------------------------------------------------------------------
// a short table of directed transactions (reset length, extreme samples,
// zero and oversized window lengths, new series, unused register address)
// is followed by about a thousand random samples in ten phases, each phase
// with its own window length and idling pattern; every accepted sample runs
// through a bit-true predictor and each result transaction is compared with
// the oldest pending expectation
// ----------------------------------------------------------------------------
module tb
    import rcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // register map and settling time of the block
    localparam logic [2:0] ADDR_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] ADDR_UNUSED        = 3'd4;
    localparam int         DRAIN_CYCLES       = 2 * MAX_WINDOW_DEF + 8;
    localparam longint     Q_MAX              = 64'sd2147483647;
    localparam longint     Q_MIN              = -64'sd2147483648;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        logic [DATA_W-1:0] ret;
        logic              sat;
    } t_window_result;

    // one line of the directed table; the expectation is only used where
    // typed is set, otherwise the predictor decides
    typedef struct packed {
        t_row_kind         kind;
        logic [2:0]        addr;
        logic [31:0]       data;
        logic              start;
        logic              typed;
        logic              has_result;
        t_window_result    result;
    } t_row;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic [DATA_W-1:0] i_sample       = '0;
    logic              i_series_start = 1'b0;
    logic              i_ready        = 1'b1;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [2:0]        paddr          = '0;
    logic [31:0]       pwdata         = '0;

    logic              o_ready;
    logic              o_valid;
    logic [DATA_W-1:0] o_window_return;
    logic              o_saturated;
    logic [31:0]       prdata;
    logic              pready;

    always #6 i_clk = ~i_clk;

    rolling_compounded_return_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_series_start  (i_series_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_window_return (o_window_return),
        .o_saturated     (o_saturated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------------
    // predictor state: sample history, write pointer, fill level, length
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] past_returns [0:MAX_WINDOW_DEF-1];
    int unsigned              next_slot;
    int unsigned              series_fill;
    logic [WLEN_W-1:0]        window_len_reg;

    t_window_result pending_returns [$];
    t_row           directed_rows [$];
    t_idle_mode     idle_mode = IDLE_NONE;

    int n_errors    = 0;
    int n_samples   = 0;
    int n_returns   = 0;
    int n_saturated = 0;

    // share of cycles in which one side holds off
    function automatic int stall_pct(input t_idle_mode mode, input bit receiver);
        case (mode)
            IDLE_SENDER:   return receiver ? 0 : 81;
            IDLE_RECEIVER: return receiver ? 81 : 0;
            IDLE_BOTH:     return 32;
            default:       return 0;
        endcase
    endfunction

    function automatic longint clamp_q824(input longint v, inout bit clipped);
        if (v > Q_MAX) begin
            clipped = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            clipped = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // store one sample and, once the window is full, compound it:
    // running value starts at 1.0, each sample oldest first gives
    // ret += floor(ret * r / 2^24) with clamping, then 1.0 is taken off
    task automatic compound_window(input logic [DATA_W-1:0] smp, input logic start,
                                   output bit produced, output t_window_result res);
        int unsigned len;
        int unsigned rd;
        longint      one;
        longint      acc;
        bit          clipped;
        len     = window_len_reg;
        one     = 64'sd1 << FRACTION_BITS_DEF;
        clipped = 1'b0;
        res     = '0;
        if (len == 0)
            len = 1;
        if (len > MAX_WINDOW_DEF)
            len = MAX_WINDOW_DEF;
        if (start) begin
            next_slot   = 0;
            series_fill = 0;
        end
        past_returns[next_slot] = smp;
        next_slot = (next_slot + 1) % MAX_WINDOW_DEF;
        if (series_fill < MAX_WINDOW_DEF)
            series_fill++;
        produced = (series_fill >= len);
        if (produced) begin
            rd  = (next_slot + MAX_WINDOW_DEF - len) % MAX_WINDOW_DEF;
            acc = one;
            for (int k = 0; k < len; k++) begin
                acc = clamp_q824(acc + ((acc * longint'(past_returns[rd]))
                                        >>> FRACTION_BITS_DEF), clipped);
                rd  = (rd + 1) % MAX_WINDOW_DEF;
            end
            acc     = clamp_q824(acc - one, clipped);
            res.ret = acc[DATA_W-1:0];
            res.sat = clipped;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the comparison
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct(idle_mode, 1'b1));
    end

    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_returns++;
            if (o_saturated)
                n_saturated++;
            if (pending_returns.size() == 0) begin
                n_errors++;
                $display("%0t: result transaction with nothing pending, actual %h sat %b",
                         $time, o_window_return, o_saturated);
            end else begin
                want = pending_returns.pop_front();
                if (o_window_return !== want.ret) begin
                    n_errors++;
                    $display("%0t: window_return mismatch, expected %h, actual %h",
                             $time, want.ret, o_window_return);
                end
                if (o_saturated !== want.sat) begin
                    n_errors++;
                    $display("%0t: saturated mismatch, expected %b, actual %b",
                             $time, want.sat, o_saturated);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------------
    // drive one sample transaction; a typed expectation overrides the
    // predictor, whose state still advances
    task automatic send_sample(input logic [DATA_W-1:0] smp, input logic start,
                               input logic typed, input logic typed_has,
                               input t_window_result typed_res);
        bit             produced;
        t_window_result res;
        int             pct;
        pct = stall_pct(idle_mode, 1'b0);
        if ($urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
        i_valid        <= 1'b1;
        i_sample       <= smp;
        i_series_start <= start;
        do @(posedge i_clk); while (!o_ready);
        n_samples++;
        compound_window(smp, start, produced, res);
        if (typed) begin
            if (typed_has)
                pending_returns.insert(pending_returns.size(), typed_res);
        end else if (produced) begin
            pending_returns.insert(pending_returns.size(), res);
        end
    endtask

    // wait for the block to go quiet, then write over apb; a window length write is read back
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        i_valid <= 1'b0;
        while (pending_returns.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WINDOW_LENGTH) begin
            window_len_reg = data[WLEN_W-1:0];
            // back-to-back read, psel stays high
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata[WLEN_W-1:0] !== data[WLEN_W-1:0]) begin
                n_errors++;
                $display("%0t: window_length read-back mismatch, expected %h, actual %h",
                         $time, data[WLEN_W-1:0], prdata[WLEN_W-1:0]);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly realistic small returns, some full-range words and corners
    function automatic logic [DATA_W-1:0] pick_sample();
        int sel;
        int small_ret;
        sel       = $urandom_range(99);
        small_ret = $urandom_range(0, 32'h7F_FFFF);
        if (sel < 60)
            return small_ret - 32'sh40_0000;
        if (sel < 85)
            return $urandom;
        case ($urandom_range(6))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFF00_0000;
            4:       return 32'h0100_0000;
            5:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic run_phase(input logic [WLEN_W-1:0] len, input t_idle_mode mode,
                             input int count, input int start_pct);
        logic [31:0] word;
        // junk in the upper bits of pwdata must not reach the register
        word = $urandom;
        word[WLEN_W-1:0] = len;
        write_register(ADDR_WINDOW_LENGTH, word);
        idle_mode = mode;
        repeat (count)
            send_sample(pick_sample(), $urandom_range(99) < start_pct, 1'b0, 1'b0, '0);
    endtask

    task automatic add_row(input t_row_kind kind, input logic [2:0] addr,
                           input logic [31:0] data, input logic start,
                           input logic typed, input logic has_result,
                           input logic [DATA_W-1:0] ret, input logic sat);
        t_row row;
        row.kind       = kind;
        row.addr       = addr;
        row.data       = data;
        row.start      = start;
        row.typed      = typed;
        row.has_result = has_result;
        row.result.ret = ret;
        row.result.sat = sat;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_row row;
        logic [WLEN_W-1:0] rnd_len;
        for (int k = 0; k < MAX_WINDOW_DEF; k++)
            past_returns[k] = '0;
        next_slot      = 0;
        series_fill    = 0;
        window_len_reg = WLEN_RESET;

        // reset length of 1: result is the sample itself unless 1.0 + r clips
        add_row(ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 32'h7EFF_FFFF, 1'b1);
        add_row(ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'hFF00_0000, 1'b0, 1'b1, 1'b1, 32'hFF00_0000, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0100_0000, 1'b0, 1'b1, 1'b1, 32'h0100_0000, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        // window of three, nothing until it fills, then a fresh series
        add_row(ROW_CONFIG, ADDR_WINDOW_LENGTH, 32'd3, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0080_0000, 1'b1, 1'b1, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0080_0000, 1'b0, 1'b1, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0080_0000, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'hFF00_0000, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0010_0000, 1'b1, 1'b1, 1'b0, '0, 1'b0);
        // zero length behaves as one
        add_row(ROW_CONFIG, ADDR_WINDOW_LENGTH, 32'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h1234_5678, 1'b0, 1'b1, 1'b1, 32'h1234_5678, 1'b0);
        // length two: clipping on both sides and floor rounding of negatives
        add_row(ROW_CONFIG, ADDR_WINDOW_LENGTH, 32'd2, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0000_0001, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        // a write to an unmapped address leaves the length alone
        add_row(ROW_CONFIG, ADDR_UNUSED, 32'd5, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0000_0003, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        // only the low seven bits count
        add_row(ROW_CONFIG, ADDR_WINDOW_LENGTH, 32'hFFFF_FF81, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h4000_0000, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        // oversized length acts as the full depth, series is far short of it
        add_row(ROW_CONFIG, ADDR_WINDOW_LENGTH, 32'd100, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, '0, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CONFIG)
                write_register(row.addr, row.data);
            else
                send_sample(row.data, row.start, row.typed, row.has_result, row.result);
        end

        // random phases; series carry over, so each new length also lands
        // in the middle of a series
        run_phase(7'd1,   IDLE_NONE,     100, 10);
        run_phase(7'd0,   IDLE_SENDER,    60, 10);
        run_phase(7'd4,   IDLE_RECEIVER, 120,  8);
        run_phase(7'd64,  IDLE_NONE,     140,  1);
        run_phase(7'd127, IDLE_BOTH,      80,  1);
        run_phase(7'd12,  IDLE_BOTH,     120,  5);
        run_phase(7'd2,   IDLE_SENDER,   100, 10);
        rnd_len = WLEN_W'($urandom_range(1, 16));
        run_phase(rnd_len, IDLE_RECEIVER, 120, 5);
        run_phase(7'd33,  IDLE_NONE,      80,  2);
        rnd_len = WLEN_W'($urandom_range(1, 24));
        run_phase(rnd_len, IDLE_BOTH,     80,  3);

        i_valid <= 1'b0;
        while (pending_returns.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples and %0d window returns (%0d clipped)",
                 n_samples, n_returns, n_saturated);
        $display("window lengths 0 to 127 tried under four idling patterns, %0d errors",
                 n_errors);
        if (n_errors == 0)
            $display("rolling_compounded_return_unit regression: pass");
        else
            $display("rolling_compounded_return_unit regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("timeout with %0d results still pending", pending_returns.size());
        $display("rolling_compounded_return_unit regression: fail");
        $finish;
    end

endmodule
